// File: rtl/core/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// Widths, register map, lane numbering and shared types of the radar
// measurement Jacobian pipeline.
// ----------------------------------------------------------------------------
package rmj_pkg;

  // Fixed-point format of every input and output entry
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // Configuration register map
  localparam int MS_W      = 17;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int PDATA_W   = 32;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SQUARE = REG_IDX_W'(0);
  localparam logic [MS_W-1:0]      MS_RESET       = MS_W'(7);

  // Square sum and square root
  localparam int SQ_W        = 2 * DATA_W;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int SQ_REM_W    = ROOT_W + 3;

  // Cross term and rate numerators
  localparam int CROSS_W = 2 * DATA_W;
  localparam int HALF_W  = CROSS_W / 2;
  localparam int PROD_W  = DATA_W + CROSS_W;
  localparam int T_W     = PROD_W + FRAC_BITS;
  localparam int Q1_W    = SQ_W;

  // Final divides: one quotient bit more than the output for clipping
  localparam int QUO_W     = DATA_W + 1;
  localparam int RNG_NUM_W = DATA_W + FRAC_BITS;
  localparam int BRG_NUM_W = DATA_W + 2 * FRAC_BITS;

  localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(1) << (DATA_W - 1);
  localparam logic [QUO_W-1:0] LIM_POS = LIM_NEG - QUO_W'(1);

  // Divider lanes: the first N_NARROW divide by the root, the rest by s
  localparam int N_LANES  = 6;
  localparam int N_NARROW = 4;
  localparam int N_WIDE   = N_LANES - N_NARROW;
  localparam int LANE_RNG_X  = 0;
  localparam int LANE_RNG_Y  = 1;
  localparam int LANE_RATE_X = 2;
  localparam int LANE_RATE_Y = 3;
  localparam int LANE_BRG_X  = 4;
  localparam int LANE_BRG_Y  = 5;

  // Per-item values carried alongside the square root and first divide
  typedef struct packed {
    logic [DATA_W-1:0] pm;
    logic [DATA_W-1:0] qm;
    logic              pn;
    logic              qn;
    logic              cn;
    logic              fl;
    logic [SQ_W-1:0]   s;
  } base_t;

endpackage

// File: rtl/core/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Fixed-point radar measurement Jacobian: six distinct nonzero entries from
// one position and velocity vector, fully pipelined.
// ----------------------------------------------------------------------------
// A state vector is taken on every clock edge with start high; busy is always
// low, so one vector per cycle is sustained. Each result appears on the out_
// ports for one cycle with out_valid high, in order. Counting register
// stages after the capture edge, the path runs through four front stages
// (magnitudes and cross products, squares, square sum, floor), the 32-step
// square root, a load stage and the 64-step divide of the rate numerators
// by s, a load stage and the 33-step final divides, and the output register
// with clipping. The min_square register is meant to be written only while
// the pipeline is empty.
module radar_measurement_jacobian
  import rmj_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic signed [DATA_W-1:0] in_vel_x,
  input  logic signed [DATA_W-1:0] in_vel_y,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_range_by_px,
  output logic signed [DATA_W-1:0] out_range_by_py,
  output logic signed [DATA_W-1:0] out_bearing_by_px,
  output logic signed [DATA_W-1:0] out_bearing_by_py,
  output logic signed [DATA_W-1:0] out_rate_by_px,
  output logic signed [DATA_W-1:0] out_rate_by_py,
  output logic                     out_floor_applied,
  output logic                     out_saturated,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [MS_W-1:0] min_square_r;
  logic            reg_sel;
  logic [MS_W-1:0] ms_eff;

  assign reg_sel = (paddr[ADDR_W-1:2] == REG_MIN_SQUARE);
  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign prdata  = reg_sel ? PDATA_W'(min_square_r) : '0;
  assign ms_eff  = (min_square_r == '0) ? MS_W'(1) : min_square_r;

  // Take the register on a completed write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_square_r <= MS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_square_r <= pwdata[MS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: capture, magnitudes and cross products, squares, sum
  // --------------------------------------------------------------------------
  logic                     v0_r, v1_r, v2_r, v3_r;
  logic signed [DATA_W-1:0] p0_r, q0_r, vx0_r, vy0_r;
  logic [DATA_W-1:0]        pm1_r, qm1_r, pm2_r, qm2_r, pm3_r, qm3_r;
  logic                     pn1_r, qn1_r, pn2_r, qn2_r, pn3_r, qn3_r;
  logic signed [SQ_W-1:0]   a1_r, b1_r;
  logic [SQ_W-1:0]          pp2_r, qq2_r, s3_r;
  logic [CROSS_W-1:0]       cm2_r;
  logic                     cn2_r, cn3_r;
  logic [SQ_W-1:0]          qlo3_r, qhi3_r, plo3_r, phi3_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Capture the vector, form magnitudes and the two cross products
  always_ff @(posedge clk) begin
    p0_r  <= in_pos_x;
    q0_r  <= in_pos_y;
    vx0_r <= in_vel_x;
    vy0_r <= in_vel_y;

    pm1_r <= p0_r[DATA_W-1] ? DATA_W'(-p0_r) : DATA_W'(p0_r);
    qm1_r <= q0_r[DATA_W-1] ? DATA_W'(-q0_r) : DATA_W'(q0_r);
    pn1_r <= p0_r[DATA_W-1];
    qn1_r <= q0_r[DATA_W-1];
    a1_r  <= vx0_r * q0_r;
    b1_r  <= vy0_r * p0_r;
  end

  // Square the magnitudes, take sign and magnitude of the cross term
  always_ff @(posedge clk) begin
    pp2_r <= pm1_r * pm1_r;
    qq2_r <= qm1_r * qm1_r;
    if (a1_r >= b1_r) begin
      cm2_r <= CROSS_W'($unsigned(a1_r) - $unsigned(b1_r));
      cn2_r <= 1'b0;
    end else begin
      cm2_r <= CROSS_W'($unsigned(b1_r) - $unsigned(a1_r));
      cn2_r <= 1'b1;
    end
    pm2_r <= pm1_r;
    qm2_r <= qm1_r;
    pn2_r <= pn1_r;
    qn2_r <= qn1_r;
  end

  // Sum the squares, split the rate products into halves
  always_ff @(posedge clk) begin
    s3_r   <= pp2_r + qq2_r;
    qlo3_r <= qm2_r * cm2_r[HALF_W-1:0];
    qhi3_r <= qm2_r * cm2_r[CROSS_W-1:HALF_W];
    plo3_r <= pm2_r * cm2_r[HALF_W-1:0];
    phi3_r <= pm2_r * cm2_r[CROSS_W-1:HALF_W];
    pm3_r  <= pm2_r;
    qm3_r  <= qm2_r;
    pn3_r  <= pn2_r;
    qn3_r  <= qn2_r;
    cn3_r  <= cn2_r;
  end

  // --------------------------------------------------------------------------
  // Square root, one result bit per stage; stage 0 applies the floor
  // --------------------------------------------------------------------------
  logic                sq_vld_r  [0:SQRT_STAGES];
  base_t               sq_base_r [0:SQRT_STAGES];
  logic [PROD_W-1:0]   sq_qc_r   [0:SQRT_STAGES];
  logic [PROD_W-1:0]   sq_pc_r   [0:SQRT_STAGES];
  logic [SQ_W-1:0]     sq_rad_r  [0:SQRT_STAGES];
  logic [SQ_REM_W-1:0] sq_rem_r  [0:SQRT_STAGES];
  logic [ROOT_W-1:0]   sq_root_r [0:SQRT_STAGES];

  logic [SQ_W-1:0] floor_v;
  logic            below;
  base_t           base0_nxt;

  assign floor_v = SQ_W'(ms_eff) << FRAC_BITS;
  assign below   = (s3_r < floor_v);

  always_comb begin
    base0_nxt.pm = pm3_r;
    base0_nxt.qm = qm3_r;
    base0_nxt.pn = pn3_r;
    base0_nxt.qn = qn3_r;
    base0_nxt.cn = cn3_r;
    base0_nxt.fl = below;
    base0_nxt.s  = below ? floor_v : s3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= v3_r;
    end
  end

  // Raise s to the floor, join the product halves, load the root
  always_ff @(posedge clk) begin
    sq_base_r[0] <= base0_nxt;
    sq_qc_r[0]   <= PROD_W'(qlo3_r) + (PROD_W'(qhi3_r) << HALF_W);
    sq_pc_r[0]   <= PROD_W'(plo3_r) + (PROD_W'(phi3_r) << HALF_W);
    sq_rad_r[0]  <= base0_nxt.s;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {sq_rem_r[k-1][SQ_REM_W-3:0], sq_rad_r[k-1][SQ_W-1 -: 2]};
      trial  = SQ_REM_W'({sq_root_r[k-1], 2'b01});
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      sq_base_r[k] <= sq_base_r[k-1];
      sq_qc_r[k]   <= sq_qc_r[k-1];
      sq_pc_r[k]   <= sq_pc_r[k-1];
      sq_rad_r[k]  <= sq_rad_r[k-1] << 2;
      sq_rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
      sq_root_r[k] <= {sq_root_r[k-1][ROOT_W-2:0], ge};
    end
  end

  // --------------------------------------------------------------------------
  // First rate divide: both rate numerators by s, one quotient bit a stage
  // Lane 0 carries the y-weighted numerator, lane 1 the x-weighted one.
  // --------------------------------------------------------------------------
  logic                       d1_vld_r  [0:Q1_W];
  base_t                      d1_base_r [0:Q1_W];
  logic [ROOT_W-1:0]          d1_root_r [0:Q1_W];
  logic [1:0][SQ_W-1:0]       d1_rem_r  [0:Q1_W];
  logic [1:0][Q1_W-1:0]       d1_num_r  [0:Q1_W];
  logic [1:0][Q1_W-1:0]       d1_quo_r  [0:Q1_W];
  logic [1:0]                 d1_ovf_r  [0:Q1_W];

  logic [1:0][T_W-1:0] t_nxt;

  assign t_nxt[0] = {sq_qc_r[SQRT_STAGES], FRAC_BITS'(0)};
  assign t_nxt[1] = {sq_pc_r[SQRT_STAGES], FRAC_BITS'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r[0] <= 1'b0;
    end else begin
      d1_vld_r[0] <= sq_vld_r[SQRT_STAGES];
    end
  end

  // Load the upper numerator bits; flag a quotient that cannot fit
  always_ff @(posedge clk) begin
    d1_base_r[0] <= sq_base_r[SQRT_STAGES];
    d1_root_r[0] <= sq_root_r[SQRT_STAGES];
    for (int l = 0; l < 2; l++) begin
      d1_rem_r[0][l] <= SQ_W'(t_nxt[l][T_W-1:Q1_W]);
      d1_num_r[0][l] <= t_nxt[l][Q1_W-1:0];
      d1_quo_r[0][l] <= '0;
      d1_ovf_r[0][l] <= (t_nxt[l][T_W-1:Q1_W] >= sq_base_r[SQRT_STAGES].s);
    end
  end

  for (genvar j = 1; j <= Q1_W; j++) begin : g_div1
    logic [1:0][SQ_W:0]   rem_sh;
    logic [1:0]           ge;
    logic [1:0][SQ_W-1:0] rem_nxt;

    // Shift in a numerator bit, subtract s where it fits
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_sh[l]  = {d1_rem_r[j-1][l], d1_num_r[j-1][l][Q1_W-1]};
        ge[l]      = (rem_sh[l] >= {1'b0, d1_base_r[j-1].s});
        rem_nxt[l] = ge[l] ? SQ_W'(rem_sh[l] - {1'b0, d1_base_r[j-1].s})
                           : rem_sh[l][SQ_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_vld_r[j] <= 1'b0;
      end else begin
        d1_vld_r[j] <= d1_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      d1_base_r[j] <= d1_base_r[j-1];
      d1_root_r[j] <= d1_root_r[j-1];
      d1_ovf_r[j]  <= d1_ovf_r[j-1];
      for (int l = 0; l < 2; l++) begin
        d1_rem_r[j][l] <= rem_nxt[l];
        d1_num_r[j][l] <= d1_num_r[j-1][l] << 1;
        d1_quo_r[j][l] <= {d1_quo_r[j-1][l][Q1_W-2:0], ge[l]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final divides: six lanes, 33 quotient bits each
  // --------------------------------------------------------------------------
  logic                          p2_vld_r  [0:QUO_W];
  logic                          p2_fl_r   [0:QUO_W];
  logic [N_LANES-1:0]            p2_neg_r  [0:QUO_W];
  logic [N_LANES-1:0]            p2_ovf_r  [0:QUO_W];
  logic [N_LANES-1:0][QUO_W-1:0] p2_num_r  [0:QUO_W];
  logic [N_LANES-1:0][QUO_W-1:0] p2_quo_r  [0:QUO_W];
  logic [N_NARROW-1:0][ROOT_W-1:0] p2_rn_r [0:QUO_W];
  logic [N_WIDE-1:0][SQ_W-1:0]   p2_rw_r   [0:QUO_W];
  logic [ROOT_W-1:0]             p2_root_r [0:QUO_W];
  logic [SQ_W-1:0]               p2_s_r    [0:QUO_W];

  base_t                         b_in;
  logic [ROOT_W-1:0]             r_in;
  logic [RNG_NUM_W-1:0]          rng_num [2];
  logic [BRG_NUM_W-1:0]          brg_num [2];
  logic [N_LANES-1:0]            neg0_nxt;
  logic [N_LANES-1:0]            ovf0_nxt;
  logic [N_LANES-1:0][QUO_W-1:0] num0_nxt;
  logic [N_NARROW-1:0][ROOT_W-1:0] rn0_nxt;
  logic [N_WIDE-1:0][SQ_W-1:0]   rw0_nxt;

  // Build the six numerators, their signs and overflow flags
  always_comb begin
    b_in = d1_base_r[Q1_W];
    r_in = d1_root_r[Q1_W];
    rng_num[0] = {b_in.pm, FRAC_BITS'(0)};
    rng_num[1] = {b_in.qm, FRAC_BITS'(0)};
    brg_num[0] = {b_in.qm, (2 * FRAC_BITS)'(0)};
    brg_num[1] = {b_in.pm, (2 * FRAC_BITS)'(0)};

    neg0_nxt[LANE_RNG_X]  = b_in.pn;
    neg0_nxt[LANE_RNG_Y]  = b_in.qn;
    neg0_nxt[LANE_RATE_X] = b_in.qn ^ b_in.cn;
    neg0_nxt[LANE_RATE_Y] = ~(b_in.pn ^ b_in.cn);
    neg0_nxt[LANE_BRG_X]  = ~b_in.qn;
    neg0_nxt[LANE_BRG_Y]  = b_in.pn;

    for (int l = 0; l < 2; l++) begin
      rn0_nxt[LANE_RNG_X + l]  = ROOT_W'(rng_num[l][RNG_NUM_W-1:QUO_W]);
      num0_nxt[LANE_RNG_X + l] = rng_num[l][QUO_W-1:0];
      ovf0_nxt[LANE_RNG_X + l] = (rng_num[l][RNG_NUM_W-1:QUO_W] >= r_in);

      rn0_nxt[LANE_RATE_X + l]  = ROOT_W'(d1_quo_r[Q1_W][l][Q1_W-1:QUO_W]);
      num0_nxt[LANE_RATE_X + l] = d1_quo_r[Q1_W][l][QUO_W-1:0];
      ovf0_nxt[LANE_RATE_X + l] = d1_ovf_r[Q1_W][l] ||
                                  (d1_quo_r[Q1_W][l][Q1_W-1:QUO_W] >= r_in);

      rw0_nxt[l]               = SQ_W'(brg_num[l][BRG_NUM_W-1:QUO_W]);
      num0_nxt[LANE_BRG_X + l] = brg_num[l][QUO_W-1:0];
      ovf0_nxt[LANE_BRG_X + l] = (brg_num[l][BRG_NUM_W-1:QUO_W] >= b_in.s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r[0] <= 1'b0;
    end else begin
      p2_vld_r[0] <= d1_vld_r[Q1_W];
    end
  end

  always_ff @(posedge clk) begin
    p2_fl_r[0]   <= b_in.fl;
    p2_neg_r[0]  <= neg0_nxt;
    p2_ovf_r[0]  <= ovf0_nxt;
    p2_num_r[0]  <= num0_nxt;
    p2_quo_r[0]  <= '0;
    p2_rn_r[0]   <= rn0_nxt;
    p2_rw_r[0]   <= rw0_nxt;
    p2_root_r[0] <= r_in;
    p2_s_r[0]    <= b_in.s;
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_div2
    logic [N_NARROW-1:0][ROOT_W:0]   nsh;
    logic [N_WIDE-1:0][SQ_W:0]       wsh;
    logic [N_LANES-1:0]              ge;
    logic [N_NARROW-1:0][ROOT_W-1:0] rn_nxt;
    logic [N_WIDE-1:0][SQ_W-1:0]     rw_nxt;

    // Root lanes and square-sum lanes each take one quotient bit
    always_comb begin
      for (int l = 0; l < N_NARROW; l++) begin
        nsh[l]    = {p2_rn_r[i-1][l], p2_num_r[i-1][l][QUO_W-1]};
        ge[l]     = (nsh[l] >= {1'b0, p2_root_r[i-1]});
        rn_nxt[l] = ge[l] ? ROOT_W'(nsh[l] - {1'b0, p2_root_r[i-1]})
                          : nsh[l][ROOT_W-1:0];
      end
      for (int l = 0; l < N_WIDE; l++) begin
        wsh[l]          = {p2_rw_r[i-1][l], p2_num_r[i-1][N_NARROW + l][QUO_W-1]};
        ge[N_NARROW + l] = (wsh[l] >= {1'b0, p2_s_r[i-1]});
        rw_nxt[l]       = ge[N_NARROW + l] ? SQ_W'(wsh[l] - {1'b0, p2_s_r[i-1]})
                                           : wsh[l][SQ_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p2_vld_r[i] <= 1'b0;
      end else begin
        p2_vld_r[i] <= p2_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      p2_fl_r[i]   <= p2_fl_r[i-1];
      p2_neg_r[i]  <= p2_neg_r[i-1];
      p2_ovf_r[i]  <= p2_ovf_r[i-1];
      p2_root_r[i] <= p2_root_r[i-1];
      p2_s_r[i]    <= p2_s_r[i-1];
      p2_rn_r[i]   <= rn_nxt;
      p2_rw_r[i]   <= rw_nxt;
      for (int l = 0; l < N_LANES; l++) begin
        p2_num_r[i][l] <= p2_num_r[i-1][l] << 1;
        p2_quo_r[i][l] <= {p2_quo_r[i-1][l][QUO_W-2:0], ge[l]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clip, apply signs, register the result
  // --------------------------------------------------------------------------
  logic                           out_vld_r;
  logic                           out_fl_r;
  logic                           out_sat_r;
  logic [N_LANES-1:0][DATA_W-1:0] out_val_r;

  logic [N_LANES-1:0]             clip;
  logic [N_LANES-1:0][QUO_W-1:0]  lim;
  logic [N_LANES-1:0][DATA_W-1:0] mag;
  logic [N_LANES-1:0][DATA_W-1:0] val_nxt;

  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      lim[l]     = p2_neg_r[QUO_W][l] ? LIM_NEG : LIM_POS;
      clip[l]    = p2_ovf_r[QUO_W][l] || (p2_quo_r[QUO_W][l] > lim[l]);
      mag[l]     = clip[l] ? lim[l][DATA_W-1:0] : p2_quo_r[QUO_W][l][DATA_W-1:0];
      val_nxt[l] = p2_neg_r[QUO_W][l] ? DATA_W'(-mag[l]) : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p2_vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= val_nxt;
    out_fl_r  <= p2_fl_r[QUO_W];
    out_sat_r <= |clip;
  end

  assign out_valid         = out_vld_r;
  assign out_range_by_px   = $signed(out_val_r[LANE_RNG_X]);
  assign out_range_by_py   = $signed(out_val_r[LANE_RNG_Y]);
  assign out_bearing_by_px = $signed(out_val_r[LANE_BRG_X]);
  assign out_bearing_by_py = $signed(out_val_r[LANE_BRG_Y]);
  assign out_rate_by_px    = $signed(out_val_r[LANE_RATE_X]);
  assign out_rate_by_py    = $signed(out_val_r[LANE_RATE_Y]);
  assign out_floor_applied = out_fl_r;
  assign out_saturated     = out_sat_r;

endmodule
